// ===== design/esd_pkg.sv =====
// Shared types and character constants for the escape sequence decoder.
package esd_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 12;

  // Decoder modes, one-hot.
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_BSLASH = 5'b00010,
    MODE_CARET  = 5'b00100,
    MODE_HEX    = 5'b01000,
    MODE_OCT    = 5'b10000
  } mode_t;

  // Results caused by one accepted input item.
  typedef struct packed {
    logic               two;   // second value present
    logic [VALUE_W-1:0] v0;
    logic [VALUE_W-1:0] v1;
    logic               fin;   // last value closes the text
  } grp_t;

  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UP_N   = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_UP_R   = 8'h52;
  localparam logic [CHAR_W-1:0] CH_UP_S   = 8'h53;
  localparam logic [CHAR_W-1:0] CH_UP_T   = 8'h54;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEVEN  = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

  localparam logic [CHAR_W-1:0] BS_CODE   = 8'h08;
  localparam logic [CHAR_W-1:0] FF_CODE   = 8'h0C;
  localparam logic [CHAR_W-1:0] LF_CODE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CODE   = 8'h0D;
  localparam logic [CHAR_W-1:0] SP_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CODE  = 8'h09;
  localparam logic [CHAR_W-1:0] ESC_CODE  = 8'h1B;
  localparam logic [CHAR_W-1:0] CTRL_BASE = 8'h40;
  localparam logic [3:0]        HEX_MASK  = 4'hF;
  localparam logic [2:0]        OCT_MASK  = 3'h7;

  localparam logic [1:0] MAX_DIGITS = 2'd3;

endpackage

// ===== design/esd_front.sv =====
// Front end: accepts text bytes, tracks escape state and forms result groups.
module esd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 push_valid,
  input  logic                 push_ready,
  output esd_pkg::grp_t        push_data
);

  esd_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [11:0]    acc_r, acc_nxt;

  logic           accept;
  logic [7:0]     up;
  logic           hok, ook;
  logic [3:0]     hv;
  logic [2:0]     ov;
  logic           e1, e2, e3;
  logic [11:0]    x1, x2, x3;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // digit classification and case raise
  always_comb begin
    up = ((text_byte >= esd_pkg::CH_LO_A) && (text_byte <= esd_pkg::CH_LO_Z)) ?
         (text_byte - esd_pkg::CASE_DIFF) : text_byte;
    ook = (text_byte >= esd_pkg::CH_ZERO) && (text_byte <= esd_pkg::CH_SEVEN);
    ov  = 3'(text_byte - esd_pkg::CH_ZERO) & esd_pkg::OCT_MASK;
    hok = 1'b1;
    hv  = 4'd0;
    if ((text_byte >= esd_pkg::CH_ZERO) && (text_byte <= esd_pkg::CH_NINE)) begin
      hv = 4'(text_byte - esd_pkg::CH_ZERO);
    end else if ((up >= esd_pkg::CH_UP_A) && (up <= esd_pkg::CH_UP_F)) begin
      hv = 4'(up - esd_pkg::CH_UP_A + 8'd10);
    end else begin
      hok = 1'b0;
    end
    hv = hv & esd_pkg::HEX_MASK;
  end

  always_comb begin
    logic       do_fresh;
    logic       ok;
    logic [1:0] c_inc;
    logic [11:0] a_sh;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    e1 = 1'b0; e2 = 1'b0; e3 = 1'b0;
    x1 = '0;   x2 = '0;   x3 = '0;
    do_fresh = 1'b1;
    ok    = (mode_r == esd_pkg::MODE_HEX) ? hok : ook;
    c_inc = cnt_r + 2'd1;
    a_sh  = (mode_r == esd_pkg::MODE_HEX) ? {acc_r[7:0], hv} : {acc_r[8:0], ov};

    // stage 1: continue or close a digit run
    if ((mode_r == esd_pkg::MODE_HEX) || (mode_r == esd_pkg::MODE_OCT)) begin
      if (ok) begin
        do_fresh = 1'b0;
        acc_nxt  = a_sh;
        cnt_nxt  = c_inc;
        if (c_inc == esd_pkg::MAX_DIGITS) begin
          e1       = 1'b1;
          x1       = a_sh;
          mode_nxt = esd_pkg::MODE_NORMAL;
          cnt_nxt  = '0;
          acc_nxt  = '0;
        end
      end else begin
        e1       = 1'b1;
        x1       = acc_r;
        mode_nxt = esd_pkg::MODE_NORMAL;
        cnt_nxt  = '0;
        acc_nxt  = '0;
      end
    end

    // stage 2: decode the byte afresh
    if (do_fresh) begin
      case (mode_nxt)
        esd_pkg::MODE_BSLASH: begin
          mode_nxt = esd_pkg::MODE_NORMAL;
          e2 = 1'b1;
          case (up)
            esd_pkg::CH_UP_B: x2 = 12'(esd_pkg::BS_CODE);
            esd_pkg::CH_UP_F: x2 = 12'(esd_pkg::FF_CODE);
            esd_pkg::CH_UP_N: x2 = 12'(esd_pkg::LF_CODE);
            esd_pkg::CH_UP_R: x2 = 12'(esd_pkg::CR_CODE);
            esd_pkg::CH_UP_S: x2 = 12'(esd_pkg::SP_CODE);
            esd_pkg::CH_UP_T: x2 = 12'(esd_pkg::TAB_CODE);
            esd_pkg::CH_UP_E: x2 = 12'(esd_pkg::ESC_CODE);
            esd_pkg::CH_CARET: begin
              e2       = 1'b0;
              mode_nxt = esd_pkg::MODE_CARET;
            end
            esd_pkg::CH_UP_X: begin
              e2       = 1'b0;
              mode_nxt = esd_pkg::MODE_HEX;
              cnt_nxt  = '0;
              acc_nxt  = '0;
            end
            default: begin
              if (ook) begin
                e2       = 1'b0;
                mode_nxt = esd_pkg::MODE_OCT;
                cnt_nxt  = 2'd1;
                acc_nxt  = 12'(ov);
              end else begin
                x2 = 12'(text_byte);
              end
            end
          endcase
        end
        esd_pkg::MODE_CARET: begin
          mode_nxt = esd_pkg::MODE_NORMAL;
          e2 = 1'b1;
          x2 = 12'(8'(up - esd_pkg::CTRL_BASE));
        end
        default: begin
          mode_nxt = esd_pkg::MODE_NORMAL;
          if (text_byte == esd_pkg::CH_BSLASH) begin
            mode_nxt = esd_pkg::MODE_BSLASH;
          end else begin
            e2 = 1'b1;
            x2 = 12'(text_byte);
          end
        end
      endcase
    end

    // stage 3: flush whatever is pending at end of text
    if (end_of_text) begin
      case (mode_nxt)
        esd_pkg::MODE_BSLASH: begin
          e3 = 1'b1;
          x3 = 12'(esd_pkg::CH_BSLASH);
        end
        esd_pkg::MODE_CARET: begin
          e3 = 1'b1;
          x3 = 12'(8'(8'd0 - esd_pkg::CTRL_BASE));
        end
        esd_pkg::MODE_HEX, esd_pkg::MODE_OCT: begin
          e3 = 1'b1;
          x3 = acc_nxt;
        end
        default: e3 = 1'b0;
      endcase
      mode_nxt = esd_pkg::MODE_NORMAL;
      cnt_nxt  = '0;
      acc_nxt  = '0;
    end
  end

  // pack up to two values, in order
  always_comb begin
    push_data.two = (e1 && e2) || (e1 && e3) || (e2 && e3);
    push_data.v0  = e1 ? x1 : (e2 ? x2 : x3);
    push_data.v1  = e1 ? (e2 ? x2 : x3) : x3;
    push_data.fin = end_of_text;
  end

  assign push_valid = accept && (e1 || e2 || e3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esd_pkg::MODE_NORMAL;
      cnt_r  <= '0;
      acc_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_text |=> (mode_r == esd_pkg::MODE_NORMAL) && (cnt_r == 2'd0))
    else $error("state not cleared after end of text");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_text |-> push_valid)
    else $error("end of text produced no value");

endmodule

// ===== design/esd_queue.sv =====
// Short FIFO of result groups between front and back ends.
module esd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  esd_pkg::grp_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output esd_pkg::grp_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  esd_pkg::grp_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_fire, pop_fire;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_ready && pop_valid;

  always_comb begin
    wr_nxt    = push_fire ? ((wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt    = pop_fire  ? ((rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1) : rd_r;
    count_nxt = count_r + CW'(push_fire) - CW'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == CW'(DEPTH)) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== design/esd_back.sv =====
// Back end: holds one result group and hands its values out one per cycle while out_ready is high.
module esd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  esd_pkg::grp_t pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   char_value,
  output logic          final_result
);

  esd_pkg::grp_t grp_r;
  logic          grp_valid_r, grp_valid_nxt;
  logic          idx_r, idx_nxt;
  logic          out_fire, at_last, load;

  assign out_valid    = grp_valid_r;
  assign char_value   = idx_r ? grp_r.v1 : grp_r.v0;
  assign at_last      = (idx_r == grp_r.two);
  assign final_result = at_last && grp_r.fin;
  assign out_fire     = out_valid && out_ready;
  assign load         = !grp_valid_r || (out_fire && at_last);
  assign pop_ready    = load;

  always_comb begin
    grp_valid_nxt = grp_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      grp_valid_nxt = pop_valid;
      idx_nxt       = 1'b0;
    end else if (out_fire) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      grp_r <= pop_data;
    end
  end

  a_second_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> grp_valid_r && grp_r.two)
    else $error("second value selected without a pair");

endmodule

// ===== design/escape_sequence_decoder_unit.sv =====
// Top level of the escape sequence decoder.
// Decodes backslash-escaped text one byte per cycle: the front end takes a
// byte every cycle while the queue has room, and each byte yields zero, one
// or two character values. The output side delivers one value per cycle
// while out_tready is high, so the sustained input rate is one byte per cycle
// except where a byte yields two values (a digit run closed by a non-digit);
// the DEPTH-entry group queue absorbs such bursts. Groups are registered in
// the queue and again in the back end. in_tlast marks the end of the text;
// out_tlast marks the last value that end of text causes.
module escape_sequence_decoder_unit #(
  parameter int DEPTH = 4  // result groups buffered, 2 to 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] char_value, [15:12] zero
  output logic        out_tlast   // final_result
);

  esd_pkg::grp_t push_data, pop_data;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [11:0]   char_value;

  esd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  esd_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  esd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .char_value   (char_value),
    .final_result (out_tlast)
  );

  assign out_tdata = {4'd0, char_value};

endmodule
